// ===== rtl/pirt_pkg.sv =====
// ----------------------------------------------------------------------------
// pirt_pkg
// Shared types and constants for the pci interrupt routing table: request and
// result beats, request modes, sequencer states and memory port controls.
// ----------------------------------------------------------------------------
package pirt_pkg;

    // default table size, and fixed pin count (INTA..INTD)
    localparam int BUSES_DEF   = 16;
    localparam int DEVICES_DEF = 32;
    localparam int PINS        = 4;
    localparam int PIN_W       = 2;
    localparam int IRQ_W       = 8;

    // request modes
    typedef enum logic [1:0] {
        MODE_REG_BUS   = 2'd0,
        MODE_ADD_ROUTE = 2'd1,
        MODE_LOOKUP    = 2'd2
    } t_mode;

    // request beat
    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       bus;
        logic [7:0]       parent_bus;
        logic [5:0]       device;
        logic [2:0]       pin;
        logic [IRQ_W-1:0] irq_value;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic             ok;
        logic [IRQ_W-1:0] found_irq;
    } t_out_item;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_EVAL,
        S_DONE
    } t_state;

    // memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // index width for a table of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/pirt_irq_ram.sv =====
// ----------------------------------------------------------------------------
// pirt_irq_ram
// IRQ entry store, one byte per bus, device and pin. Single port, registered
// read data.
// ----------------------------------------------------------------------------
module pirt_irq_ram #(
    parameter int AW = 11
) (
    input  logic                     i_clk,
    input  pirt_pkg::t_mem_ctl       i_ctl,
    input  logic [AW-1:0]            i_addr,
    input  logic [pirt_pkg::IRQ_W-1:0] i_wdata,
    output logic [pirt_pkg::IRQ_W-1:0] o_rdata
);
    import pirt_pkg::*;

    logic [IRQ_W-1:0] mem [2**AW];
    logic [IRQ_W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pirt_bus_tbl.sv =====
// ----------------------------------------------------------------------------
// pirt_bus_tbl
// Per-bus table: valid marks in flops cleared at reset, parent bus and
// bridge slot in a small memory with registered read.
// ----------------------------------------------------------------------------
module pirt_bus_tbl #(
    parameter  int BUSES   = pirt_pkg::BUSES_DEF,
    parameter  int DEVICES = pirt_pkg::DEVICES_DEF,
    localparam int BW      = pirt_pkg::idx_w(BUSES),
    localparam int DW      = pirt_pkg::idx_w(DEVICES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pirt_pkg::t_mem_ctl i_ctl,
    input  logic [BW-1:0]      i_addr,
    input  logic [BW-1:0]      i_wparent,
    input  logic [DW-1:0]      i_wslot,
    output logic [BW-1:0]      o_parent,
    output logic [DW-1:0]      o_slot,
    input  logic [BW-1:0]      i_vld_addr,
    output logic               o_vld
);
    import pirt_pkg::*;

    logic [BUSES-1:0]  r_valid;
    logic [BW+DW-1:0]  mem [BUSES];
    logic [BW+DW-1:0]  r_rdata;

    // valid marks, set when a bus is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // parent and bridge slot store
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= {i_wparent, i_wslot};
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_parent = r_rdata[BW+DW-1:DW];
    assign o_slot   = r_rdata[DW-1:0];
    assign o_vld    = r_valid[i_vld_addr];

endmodule

// ===== rtl/pirt_seq.sv =====
// ----------------------------------------------------------------------------
// pirt_seq
// Request sequencer: checks arguments, registers buses with a clearing
// sweep, stores routes, and walks lookups up the bridge chain one level
// per cycle with the swizzle adder.
// ----------------------------------------------------------------------------
module pirt_seq #(
    parameter  int BUSES   = pirt_pkg::BUSES_DEF,
    parameter  int DEVICES = pirt_pkg::DEVICES_DEF,
    localparam int BW      = pirt_pkg::idx_w(BUSES),
    localparam int DW      = pirt_pkg::idx_w(DEVICES),
    localparam int AW      = BW + DW + pirt_pkg::PIN_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  pirt_pkg::t_in_item         i_in_data,
    output logic                       o_idle,
    output logic                       o_res_valid,
    output pirt_pkg::t_out_item        o_res,
    input  logic                       i_res_take,
    output pirt_pkg::t_mem_ctl         o_irq_ctl,
    output logic [AW-1:0]              o_irq_addr,
    output logic [pirt_pkg::IRQ_W-1:0] o_irq_wdata,
    input  logic [pirt_pkg::IRQ_W-1:0] i_irq_rdata,
    output pirt_pkg::t_mem_ctl         o_tbl_ctl,
    output logic [BW-1:0]              o_tbl_addr,
    output logic [BW-1:0]              o_tbl_wparent,
    output logic [DW-1:0]              o_tbl_wslot,
    input  logic [BW-1:0]              i_tbl_parent,
    input  logic [DW-1:0]              i_tbl_slot,
    output logic [BW-1:0]              o_vld_addr,
    input  logic                       i_vld
);
    import pirt_pkg::*;

    localparam int SW = $clog2(BUSES + 1);
    localparam int CW = DW + PIN_W;

    t_state     r_state, n_state;
    t_in_item   r_in, n_in;
    t_out_item  r_res, n_res;
    logic [BW-1:0]    r_cur, n_cur;
    logic [PIN_W-1:0] r_off, n_off;
    logic [SW-1:0]    r_steps, n_steps;
    logic [CW-1:0]    r_sweep, n_sweep;

    logic             bus_ok, par_ok, dev_ok, pin_ok;
    logic [PIN_W-1:0] pidx, walk_off;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_cur   <= n_cur;
        r_off   <= n_off;
        r_steps <= n_steps;
        r_sweep <= n_sweep;
    end

    // argument checks and swizzle adder
    always_comb begin
        bus_ok   = {1'b0, r_in.bus} < 9'(BUSES);
        par_ok   = {1'b0, r_in.parent_bus} < 9'(BUSES);
        dev_ok   = {1'b0, r_in.device} < 7'(DEVICES);
        pin_ok   = r_in.pin inside {[3'd1:3'd4]};
        pidx     = PIN_W'(r_in.pin - 3'd1);
        walk_off = r_off + PIN_W'(i_tbl_slot);
    end

    // next state and memory controls
    always_comb begin
        n_state       = r_state;
        n_in          = r_in;
        n_res         = r_res;
        n_cur         = r_cur;
        n_off         = r_off;
        n_steps       = r_steps;
        n_sweep       = r_sweep;
        o_irq_ctl     = '0;
        o_irq_addr    = {r_in.bus[BW-1:0], r_in.device[DW-1:0], pidx};
        o_irq_wdata   = r_in.irq_value;
        o_tbl_ctl     = '0;
        o_tbl_addr    = r_in.bus[BW-1:0];
        o_tbl_wparent = r_in.parent_bus[BW-1:0];
        o_tbl_wslot   = r_in.device[DW-1:0];
        o_vld_addr    = r_in.bus[BW-1:0];
        o_idle        = (r_state == S_IDLE);
        o_res_valid   = (r_state == S_DONE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_in.mode)
                    MODE_REG_BUS: begin
                        if (bus_ok && par_ok && dev_ok) begin
                            o_tbl_ctl.wr_en = 1'b1;
                            n_res.ok        = 1'b1;
                            n_sweep         = '0;
                            n_state         = S_CLEAR;
                        end
                    end
                    MODE_ADD_ROUTE: begin
                        if (bus_ok && dev_ok && pin_ok && i_vld) begin
                            o_irq_ctl.wr_en = 1'b1;
                            n_res.ok        = 1'b1;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (bus_ok && dev_ok && pin_ok && i_vld) begin
                            o_irq_ctl.rd_en = 1'b1;
                            o_tbl_ctl.rd_en = 1'b1;
                            n_cur           = r_in.bus[BW-1:0];
                            n_off           = PIN_W'(r_in.device) + pidx;
                            n_steps         = '0;
                            n_res.ok        = 1'b1;
                            n_state         = S_EVAL;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // zero the new bus's entries, one per cycle
            S_CLEAR: begin
                o_irq_ctl.wr_en = 1'b1;
                o_irq_addr      = {r_in.bus[BW-1:0], r_sweep};
                o_irq_wdata     = '0;
                if (r_sweep == CW'(DEVICES * PINS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_sweep = r_sweep + CW'(1);
                end
            end

            // one bridge level per cycle
            S_EVAL: begin
                o_vld_addr = i_tbl_parent;
                if (i_irq_rdata != '0 || r_steps == SW'(BUSES) || i_tbl_parent == r_cur) begin
                    n_res.found_irq = i_irq_rdata;
                    n_state         = S_DONE;
                end else if (!i_vld) begin
                    n_res.found_irq = '0;
                    n_state         = S_DONE;
                end else begin
                    o_irq_ctl.rd_en = 1'b1;
                    o_irq_addr      = {i_tbl_parent, DW'(0), walk_off};
                    o_tbl_ctl.rd_en = 1'b1;
                    o_tbl_addr      = i_tbl_parent;
                    n_cur           = i_tbl_parent;
                    n_off           = walk_off;
                    n_steps         = r_steps + SW'(1);
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== rtl/pci_irq_routing_table.sv =====
// ----------------------------------------------------------------------------
// pci_irq_routing_table
// PCI interrupt routing table with bridge pin swizzling.
//
// Requests arrive on the in channel (i_in_valid / o_in_stall, one request
// per beat) and each gives exactly one result beat on the out channel
// (o_out_valid / i_out_stall). A request is taken only while the sequencer
// is idle; o_in_stall is high while one is in work.
// Add route and any rejected request go from the check straight to the result;
// register bus first zeroes the new bus's irq entries, one per cycle on the single
// memory port, and lookup walks one bridge level per cycle, at most BUSES levels.
// The walk is bound by the registered read of the irq memory and bus table.
// Results sit in an output register; the next request is taken while a
// result waits there, and the sequencer holds its own result if the output
// register is still full. A stalled result stays unchanged until taken.
// Reset (i_rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and marks every bus unregistered; no clearing pass runs.
// ----------------------------------------------------------------------------
module pci_irq_routing_table #(
    parameter int BUSES   = pirt_pkg::BUSES_DEF,
    parameter int DEVICES = pirt_pkg::DEVICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pirt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pirt_pkg::t_out_item o_out_data
);
    import pirt_pkg::*;

    localparam int BW = idx_w(BUSES);
    localparam int DW = idx_w(DEVICES);
    localparam int AW = BW + DW + PIN_W;

    logic             seq_idle;
    logic             res_valid;
    logic             res_take;
    t_out_item        res;
    t_mem_ctl         irq_ctl;
    logic [AW-1:0]    irq_addr;
    logic [IRQ_W-1:0] irq_wdata;
    logic [IRQ_W-1:0] irq_rdata;
    t_mem_ctl         tbl_ctl;
    logic [BW-1:0]    tbl_addr;
    logic [BW-1:0]    tbl_wparent;
    logic [DW-1:0]    tbl_wslot;
    logic [BW-1:0]    tbl_parent;
    logic [DW-1:0]    tbl_slot;
    logic [BW-1:0]    vld_addr;
    logic             vld;

    logic             r_out_valid;
    t_out_item        r_out_data;

    // request sequencer
    pirt_seq #(
        .BUSES   (BUSES),
        .DEVICES (DEVICES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_idle        (seq_idle),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_take    (res_take),
        .o_irq_ctl     (irq_ctl),
        .o_irq_addr    (irq_addr),
        .o_irq_wdata   (irq_wdata),
        .i_irq_rdata   (irq_rdata),
        .o_tbl_ctl     (tbl_ctl),
        .o_tbl_addr    (tbl_addr),
        .o_tbl_wparent (tbl_wparent),
        .o_tbl_wslot   (tbl_wslot),
        .i_tbl_parent  (tbl_parent),
        .i_tbl_slot    (tbl_slot),
        .o_vld_addr    (vld_addr),
        .i_vld         (vld)
    );

    // irq entries
    pirt_irq_ram #(
        .AW (AW)
    ) u_irq_ram (
        .i_clk   (i_clk),
        .i_ctl   (irq_ctl),
        .i_addr  (irq_addr),
        .i_wdata (irq_wdata),
        .o_rdata (irq_rdata)
    );

    // per-bus valid, parent and bridge slot
    pirt_bus_tbl #(
        .BUSES   (BUSES),
        .DEVICES (DEVICES)
    ) u_bus_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_addr     (tbl_addr),
        .i_wparent  (tbl_wparent),
        .i_wslot    (tbl_wslot),
        .o_parent   (tbl_parent),
        .o_slot     (tbl_slot),
        .i_vld_addr (vld_addr),
        .o_vld      (vld)
    );

    // output register, loads when empty or when its beat leaves
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_in_stall  = !seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
